[rtl/core/gbn_pkg.sv]
`default_nettype none
package gbn_pkg;

   // fixed framing constants
   localparam int PACKET_BYTES = 2048;
   localparam int SEQ_MODULUS  = 256;

   // derived widths
   localparam int OFF_W   = $clog2(PACKET_BYTES);   // byte offset inside a packet
   localparam int SEQ_W   = $clog2(SEQ_MODULUS);    // header sequence number
   localparam int TOTAL_W = 28;                     // message length
   localparam int PKT_W   = TOTAL_W - OFF_W + 1;    // packet count, up to 2^(TOTAL_W-OFF_W)
   localparam int LEN_W   = 12;                     // payload length of one packet
   localparam int WIN_W   = 7;
   localparam int TICK_W  = 20;
   localparam int LC_W    = PKT_W;                  // signed confirmed pointer, -1 on reset
   localparam int NTS_W   = PKT_W;                  // next packet to send
   localparam int CALC_W  = PKT_W + 2;              // signed working width
   localparam int IDX_W   = 16;
   localparam int CC_W    = 17;

   // register map
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam logic [1:0] REG_WINDOW  = 2'd0;
   localparam logic [1:0] REG_TOTAL   = 2'd1;
   localparam logic [1:0] REG_TIMEOUT = 2'd2;

   typedef struct packed {
      logic             mode;
      logic [SEQ_W-1:0] ack_seq;
      logic             ack_good;
   } req_type;

   typedef struct packed {
      logic             send_valid;
      logic [IDX_W-1:0] send_index;
      logic [SEQ_W-1:0] send_seq;
      logic [LEN_W-1:0] send_length;
      logic [CC_W-1:0]  confirmed_count;
      logic             went_back;
      logic             done_res;
   } rsp_type;

   // settings as seen by the window logic
   typedef struct packed {
      logic [WIN_W-1:0]  window_size;
      logic [TICK_W-1:0] timeout_ticks;
      logic [PKT_W-1:0]  pkts;
      logic [LEN_W-1:0]  last_len;
   } cfg_type;

endpackage
`default_nettype wire

[rtl/core/gbn_csr.sv]
`default_nettype none
module gbn_csr
   import gbn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   logic [WIN_W-1:0]   window_ff,  window_in;
   logic [TOTAL_W-1:0] total_ff,   total_in;
   logic [TICK_W-1:0]  timeout_ff, timeout_in;
   logic [PKT_W-1:0]   pkts_ff,    pkts_in;
   logic [LEN_W-1:0]   last_len_ff, last_len_in;
   logic               wr_en;
   logic [1:0]         reg_sel;
   logic [TOTAL_W-1:0] wr_total;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_total   = csr_pwdata[TOTAL_W-1:0];

   // register writes, packet count and last length worked out once here
   always_comb begin
      window_in   = window_ff;
      total_in    = total_ff;
      timeout_in  = timeout_ff;
      pkts_in     = pkts_ff;
      last_len_in = last_len_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_WINDOW: begin
               window_in = csr_pwdata[WIN_W-1:0];
            end
            REG_TOTAL: begin
               total_in = wr_total;
               pkts_in  = {1'b0, wr_total[TOTAL_W-1:OFF_W]}
                        + PKT_W'(|wr_total[OFF_W-1:0]);
               if (wr_total[OFF_W-1:0] == '0) begin
                  last_len_in = LEN_W'(PACKET_BYTES);
               end else begin
                  last_len_in = LEN_W'(wr_total[OFF_W-1:0]);
               end
            end
            REG_TIMEOUT: begin
               timeout_in = csr_pwdata[TICK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WIN_W'(10);
         total_ff    <= '0;
         timeout_ff  <= TICK_W'(500);
         pkts_ff     <= '0;
         last_len_ff <= '0;
      end else begin
         window_ff   <= window_in;
         total_ff    <= total_in;
         timeout_ff  <= timeout_in;
         pkts_ff     <= pkts_in;
         last_len_ff <= last_len_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         REG_WINDOW:  csr_prdata = CSR_DW'(window_ff);
         REG_TOTAL:   csr_prdata = CSR_DW'(total_ff);
         REG_TIMEOUT: csr_prdata = CSR_DW'(timeout_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg.window_size   = window_ff;
   assign cfg.timeout_ticks = timeout_ff;
   assign cfg.pkts          = pkts_ff;
   assign cfg.last_len      = last_len_ff;

endmodule
`default_nettype wire

[rtl/core/gbn_step.sv]
`default_nettype none
module gbn_step
   import gbn_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   localparam logic signed [CALC_W-1:0] ONE_S = CALC_W'(1);
   localparam logic signed [CALC_W-1:0] MOD_S = CALC_W'(SEQ_MODULUS);
   localparam logic [TICK_W-1:0]        TICK_MAX = '1;

   logic signed [LC_W-1:0] lc_ff, lc_in;
   logic [NTS_W-1:0]       nts_ff, nts_in;
   logic [TICK_W-1:0]      since_ff, since_in;

   logic signed [CALC_W-1:0] pk, last_idx, lcx, tl, win, hm, sq, adv_lc, new_lc, cc;
   logic [TICK_W-1:0]        since_mid, since_inc;
   logic                     active, send, back, timeout;

   // one pass of the sender: issue, then handle ack or tick
   always_comb begin
      pk       = $signed({{(CALC_W-PKT_W){1'b0}}, cfg.pkts});
      last_idx = pk - ONE_S;
      lcx      = $signed({{(CALC_W-LC_W){lc_ff[LC_W-1]}}, lc_ff});
      tl       = $signed({{(CALC_W-NTS_W){1'b0}}, nts_ff});
      win      = $signed({{(CALC_W-WIN_W){1'b0}}, cfg.window_size});
      sq       = $signed({{(CALC_W-SEQ_W){1'b0}}, req.ack_seq});
      if (lc_ff[LC_W-1]) begin
         hm = -ONE_S;
      end else begin
         hm = $signed({{(CALC_W-SEQ_W){1'b0}}, lc_ff[SEQ_W-1:0]});
      end

      active = lcx < last_idx;
      send   = active && ((tl - lcx - ONE_S) < win) && (tl < pk);

      // tick counter, cleared by a send, saturating
      since_mid = send ? '0 : since_ff;
      since_inc = (since_mid == TICK_MAX) ? since_mid : since_mid + TICK_W'(1);
      timeout   = since_inc > cfg.timeout_ticks;

      // cumulative ack advance with wrap near the modulus
      adv_lc = lcx;
      if (sq >= hm) begin
         adv_lc = lcx + sq - hm;
      end else if ((hm > (MOD_S - win - ONE_S)) && (sq < win)) begin
         adv_lc = lcx + MOD_S - hm + sq;
      end
      if (adv_lc > last_idx) begin
         adv_lc = last_idx;
      end

      back     = 1'b0;
      new_lc   = lcx;
      nts_in   = nts_ff;
      since_in = since_ff;
      if (active) begin
         since_in = since_mid;
         if (send) begin
            nts_in = nts_ff + NTS_W'(1);
         end
         if (req.mode) begin
            if (!req.ack_good) begin
               back = 1'b1;
            end else begin
               new_lc = adv_lc;
            end
         end else begin
            since_in = since_inc;
            back     = timeout;
         end
         if (back) begin
            nts_in = NTS_W'(lcx + ONE_S);
         end
      end
      lc_in = new_lc[LC_W-1:0];

      cc = new_lc + ONE_S;
      if (cc > pk) begin
         cc = pk;
      end

      rsp.send_valid      = send;
      rsp.send_index      = send ? nts_ff[IDX_W-1:0] : '0;
      rsp.send_seq        = send ? nts_ff[SEQ_W-1:0] : '0;
      rsp.send_length     = '0;
      if (send) begin
         rsp.send_length = (tl == last_idx) ? cfg.last_len : LEN_W'(PACKET_BYTES);
      end
      rsp.confirmed_count = cc[CC_W-1:0];
      rsp.went_back       = back;
      rsp.done_res        = new_lc >= last_idx;
   end

   // window pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff    <= '1;
         nts_ff   <= '0;
         since_ff <= '0;
      end else if (step_en) begin
         lc_ff    <= lc_in;
         nts_ff   <= nts_in;
         since_ff <= since_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/go_back_n_sender_window_top.sv]
// channel   direction  payload    handshake
// req       in         req_type   req_valid / req_stall
// rsp       out        rsp_type   rsp_valid / rsp_stall
// csr       in/out     32-bit     apb-style, pready always high
//
// one transaction per cycle sustained while rsp_stall is low
// the pass runs between the input register and the result register, which sets rsp_valid
// synchronous active-high reset restores pointers and settings, no clearing pass
// rsp_stall holds the result register; the input register still takes one more transaction
`default_nettype none
module go_back_n_sender_window_top
   import gbn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type cfg;
   rsp_type step_rsp;
   req_type in_data_ff;
   rsp_type out_data_ff;
   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance, fire, req_take;

   gbn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gbn_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // handshake between the two registers
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire
